// ----- sv/decimal_text_to_fixed_point_top_macros.svh -----
// Assertion macros for the decimal text to fixed point block.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_TOP_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define DTFP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtfp: same-cycle check failed");
`define DTFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtfp: next-cycle check failed");
`else
`define DTFP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DTFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- sv/dtfp_pkg.sv -----
// Shared types and constants for the decimal text to fixed point block.
package dtfp_pkg;

   localparam int VALUE_BITS_DEF   = 64;
   localparam int FRAC_BITS_DEF    = 32;
   localparam int MAX_EXPONENT_DEF = 99;

   localparam int CHAR_W      = 8;
   localparam int MANT_W      = 64;
   localparam int RESULT_W    = 64;
   localparam int FCNT_W      = 5;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 72;

   localparam logic [FCNT_W-1:0] FRAC_COUNT_MAX = 5'd31;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_E_LOW = 8'h65;
   localparam logic [CHAR_W-1:0] CHAR_E_UP  = 8'h45;

   // divide by ten: q = (x * RECIP_TEN) >> RECIP_SHIFT, exact for x < 2^32
   localparam int               LIMB_W      = 16;
   localparam int               RECIP_W     = 32;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int               RECIP_SHIFT = 35;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      PH_SKIP  = 3'd0,
      PH_INT   = 3'd1,
      PH_FRAC  = 3'd2,
      PH_EMARK = 3'd3,
      PH_EDIG  = 3'd4,
      PH_DONE  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_CHECK,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      logic found;
      logic negative;
      logic saturated;
      logic net_neg;
   } job_flags_type;

   localparam int FLAGS_W = $bits(job_flags_type);

endpackage

// ----- sv/dtfp_front.sv -----
// Character parser: builds mantissa, digit count and exponent, emits one job per string.
module dtfp_front #(
   parameter int MAX_EXPONENT = dtfp_pkg::MAX_EXPONENT_DEF,
   parameter int NMAG_W       = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            take,
   input  logic [dtfp_pkg::CHAR_W-1:0]     char_code,
   input  logic                            last_char,
   output logic                            push,
   output dtfp_pkg::job_flags_type         push_flags,
   output logic [dtfp_pkg::MANT_W-1:0]     push_mant,
   output logic [NMAG_W-1:0]               push_net_mag
);
   import dtfp_pkg::*;

   localparam int EXP_W   = $clog2(MAX_EXPONENT + 1);
   localparam int EPROD_W = EXP_W + 4;
   localparam int NW      = NMAG_W + 1;
   localparam int MX_W    = MANT_W + 4;
   localparam logic [EXP_W-1:0] EXP_CAP = EXP_W'(MAX_EXPONENT);

   phase_type           phase_ff, phase_in;
   logic                negative_ff, negative_in;
   logic [MANT_W-1:0]   mant_ff, mant_in;
   logic [FCNT_W-1:0]   fcnt_ff, fcnt_in;
   logic [EXP_W-1:0]    exp_ff, exp_in;
   logic                exp_neg_ff, exp_neg_in;
   logic                sat_ff, sat_in;

   logic                is_digit;
   logic                is_e;
   logic [3:0]          digit;
   logic [MX_W-1:0]     mant_ext;
   logic [MX_W-1:0]     mant_x10;
   logic                mant_fits;
   logic [EPROD_W-1:0]  exp_ext;
   logic [EPROD_W-1:0]  exp_x10;
   logic [EXP_W-1:0]    exp_sat;
   logic [NW-1:0]       exp_w;
   logic [NW-1:0]       fc_w;
   logic [NW-1:0]       net_mag;
   logic                net_neg;

   always_comb begin
      is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      is_e      = (char_code == CHAR_E_LOW) || (char_code == CHAR_E_UP);
      digit     = 4'(char_code - CHAR_ZERO);
      mant_ext  = MX_W'(mant_ff);
      mant_x10  = (mant_ext << 3) + (mant_ext << 1) + MX_W'(digit);
      mant_fits = (mant_x10[MX_W-1:MANT_W] == 4'd0);
      exp_ext   = EPROD_W'(exp_ff);
      exp_x10   = (exp_ext << 3) + (exp_ext << 1) + EPROD_W'(digit);
      exp_sat   = (exp_x10 > EPROD_W'(EXP_CAP)) ? EXP_CAP : exp_x10[EXP_W-1:0];
   end

   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      mant_in     = mant_ff;
      fcnt_in     = fcnt_ff;
      exp_in      = exp_ff;
      exp_neg_in  = exp_neg_ff;
      sat_in      = sat_ff;
      unique case (phase_ff)
         PH_SKIP: begin
            if (is_digit) begin
               mant_in  = MANT_W'(digit);
               phase_in = PH_INT;
            end else if (char_code == CHAR_MINUS) begin
               negative_in = 1'b1;
               phase_in    = PH_INT;
            end
         end
         PH_INT: begin
            if (is_digit) begin
               if (mant_fits) mant_in = mant_x10[MANT_W-1:0];
               else sat_in = 1'b1;
            end else if (char_code == CHAR_POINT) begin
               phase_in = PH_FRAC;
            end else if (is_e) begin
               phase_in = PH_EMARK;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_FRAC: begin
            if (is_digit) begin
               if ((fcnt_ff < FRAC_COUNT_MAX) && mant_fits) begin
                  mant_in = mant_x10[MANT_W-1:0];
                  fcnt_in = fcnt_ff + FCNT_W'(1);
               end
            end else if (is_e) begin
               phase_in = PH_EMARK;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_EMARK: begin
            if (char_code == CHAR_PLUS) begin
               phase_in = PH_EDIG;
            end else if (char_code == CHAR_MINUS) begin
               exp_neg_in = 1'b1;
               phase_in   = PH_EDIG;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_EDIG: begin
            if (is_digit) exp_in = exp_sat;
            else phase_in = PH_DONE;
         end
         default: ;
      endcase
   end

   // net power of ten = +/-exponent - fraction digits, as sign and magnitude
   always_comb begin
      exp_w = NW'(exp_in);
      fc_w  = NW'(fcnt_in);
      if (exp_neg_in) begin
         net_mag = exp_w + fc_w;
         net_neg = (net_mag != '0);
      end else if (exp_w >= fc_w) begin
         net_mag = exp_w - fc_w;
         net_neg = 1'b0;
      end else begin
         net_mag = fc_w - exp_w;
         net_neg = 1'b1;
      end
   end

   assign push                 = take && last_char;
   assign push_flags.found     = (phase_in != PH_SKIP);
   assign push_flags.negative  = negative_in;
   assign push_flags.saturated = sat_in;
   assign push_flags.net_neg   = net_neg;
   assign push_mant            = mant_in;
   assign push_net_mag         = net_mag[NMAG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset || push) begin
         phase_ff    <= PH_SKIP;
         negative_ff <= 1'b0;
         mant_ff     <= '0;
         fcnt_ff     <= '0;
         exp_ff      <= '0;
         exp_neg_ff  <= 1'b0;
         sat_ff      <= 1'b0;
      end else if (take) begin
         phase_ff    <= phase_in;
         negative_ff <= negative_in;
         mant_ff     <= mant_in;
         fcnt_ff     <= fcnt_in;
         exp_ff      <= exp_in;
         exp_neg_ff  <= exp_neg_in;
         sat_ff      <= sat_in;
      end
   end

endmodule

// ----- sv/dtfp_queue.sv -----
// Short job queue between the parser and the scaler.
module dtfp_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              not_empty
);
   import dtfp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- sv/dtfp_back.sv -----
// Scaler: applies the power of ten by repeated x10 or limb-serial /10, clamps, registers the word.
module dtfp_back #(
   parameter int VALUE_BITS = dtfp_pkg::VALUE_BITS_DEF,
   parameter int FRAC_BITS  = dtfp_pkg::FRAC_BITS_DEF,
   parameter int NMAG_W     = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             job_valid,
   input  dtfp_pkg::job_flags_type          job_flags,
   input  logic [dtfp_pkg::MANT_W-1:0]      job_mant,
   input  logic [NMAG_W-1:0]                job_net_mag,
   output logic                             job_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [dtfp_pkg::RESULT_W-1:0]    rsp_value,
   output logic                             rsp_found,
   output logic                             rsp_overflow
);
   import dtfp_pkg::*;

   localparam int NUM_W      = MANT_W + FRAC_BITS;
   localparam int LIMB_COUNT = (NUM_W + LIMB_W - 1) / LIMB_W;
   localparam int WORK_W     = LIMB_COUNT * LIMB_W;
   localparam int LIDX_W     = $clog2(LIMB_COUNT);
   localparam int DIG_W      = LIMB_W + 4;
   localparam int PROD_W     = DIG_W + RECIP_W;
   localparam int MX_W       = MANT_W + 4;
   localparam logic [RESULT_W-1:0] HALF = RESULT_W'(1) << (VALUE_BITS - 1);
   localparam logic [LIDX_W-1:0]   LIMB_LAST = LIDX_W'(LIMB_COUNT - 1);

   back_state_type          state_ff, state_in;
   logic                    neg_ff, neg_in;
   logic                    found_ff, found_in;
   logic                    ovf_ff, ovf_in;
   logic [VALUE_BITS-1:0]   mag_ff, mag_in;
   logic [WORK_W-1:0]       work_ff, work_in;
   logic [NMAG_W-1:0]       cnt_ff, cnt_in;
   logic [LIDX_W-1:0]       limb_ff, limb_in;
   logic [3:0]              rem_ff, rem_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   logic [RESULT_W-1:0]     job_lim;
   logic [RESULT_W-1:0]     job_ilim;
   logic [RESULT_W-1:0]     lim;
   logic [RESULT_W-1:0]     ilim;
   logic [MANT_W-1:0]       p_cur;
   logic [MX_W-1:0]         p_ext;
   logic [MX_W-1:0]         p_x10;
   logic [RESULT_W-1:0]     p_shifted;
   logic [DIG_W-1:0]        div_x;
   logic [PROD_W-1:0]       div_prod;
   logic [LIMB_W-1:0]       div_q;
   logic [DIG_W-1:0]        div_q_ext;
   logic [DIG_W-1:0]        div_r;
   logic [RESULT_W-1:0]     mag_ext;
   logic                    out_free;

   always_comb begin
      job_lim   = job_flags.negative ? HALF : HALF - RESULT_W'(1);
      job_ilim  = job_lim >> FRAC_BITS;
      lim       = neg_ff ? HALF : HALF - RESULT_W'(1);
      ilim      = lim >> FRAC_BITS;
      p_cur     = work_ff[MANT_W-1:0];
      p_ext     = MX_W'(p_cur);
      p_x10     = (p_ext << 3) + (p_ext << 1);
      p_shifted = RESULT_W'(p_cur) << FRAC_BITS;
      // one 16-bit limb of the running /10, most significant limb first
      div_x     = {rem_ff, work_ff[WORK_W-1 -: LIMB_W]};
      div_prod  = PROD_W'(div_x) * PROD_W'(RECIP_TEN);
      div_q     = div_prod[RECIP_SHIFT +: LIMB_W];
      div_q_ext = DIG_W'(div_q);
      div_r     = div_x - (div_q_ext << 3) - (div_q_ext << 1);
      mag_ext   = RESULT_W'(mag_ff);
      out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      found_in     = found_ff;
      ovf_in       = ovf_ff;
      mag_in       = mag_ff;
      work_in      = work_ff;
      cnt_in       = cnt_ff;
      limb_in      = limb_ff;
      rem_in       = rem_ff;
      job_pop      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               neg_in   = job_flags.negative;
               found_in = job_flags.found;
               ovf_in   = 1'b0;
               mag_in   = '0;
               work_in  = WORK_W'(job_mant);
               cnt_in   = job_net_mag;
               limb_in  = '0;
               rem_in   = 4'd0;
               state_in = BK_FINISH;
               if (!job_flags.found || job_mant == '0) begin
                  if (job_flags.found && job_flags.saturated) begin
                     ovf_in = 1'b1;
                     mag_in = job_lim[VALUE_BITS-1:0];
                  end
               end else if (job_flags.saturated) begin
                  ovf_in = 1'b1;
                  mag_in = job_lim[VALUE_BITS-1:0];
               end else if (!job_flags.net_neg) begin
                  if (RESULT_W'(job_mant) > job_ilim) begin
                     ovf_in = 1'b1;
                     mag_in = job_lim[VALUE_BITS-1:0];
                  end else begin
                     state_in = BK_MUL;
                  end
               end else begin
                  work_in  = WORK_W'(job_mant) << FRAC_BITS;
                  state_in = BK_DIV;
               end
            end
         end
         BK_MUL: begin
            if (cnt_ff == '0) begin
               mag_in   = p_shifted[VALUE_BITS-1:0];
               state_in = BK_FINISH;
            end else if (p_x10 > MX_W'(ilim)) begin
               ovf_in   = 1'b1;
               mag_in   = lim[VALUE_BITS-1:0];
               state_in = BK_FINISH;
            end else begin
               work_in = WORK_W'(p_x10[MANT_W-1:0]);
               cnt_in  = cnt_ff - NMAG_W'(1);
            end
         end
         BK_DIV: begin
            if (limb_ff == '0 && (cnt_ff == '0 || work_ff == '0)) begin
               state_in = BK_CHECK;
            end else begin
               work_in = {work_ff[WORK_W-LIMB_W-1:0], div_q};
               if (limb_ff == LIMB_LAST) begin
                  limb_in = '0;
                  rem_in  = 4'd0;
                  cnt_in  = cnt_ff - NMAG_W'(1);
               end else begin
                  limb_in = limb_ff + LIDX_W'(1);
                  rem_in  = div_r[3:0];
               end
            end
         end
         BK_CHECK: begin
            if (work_ff > WORK_W'(lim)) begin
               ovf_in = 1'b1;
               mag_in = lim[VALUE_BITS-1:0];
            end else begin
               mag_in = work_ff[VALUE_BITS-1:0];
            end
            state_in = BK_FINISH;
         end
         BK_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = neg_ff ? RESULT_W'(0) - mag_ext : mag_ext;
               rsp_found_in = found_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      found_ff     <= found_in;
      ovf_ff       <= ovf_in;
      mag_ff       <= mag_in;
      work_ff      <= work_in;
      cnt_ff       <= cnt_in;
      limb_ff      <= limb_in;
      rem_ff       <= rem_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

// ----- sv/decimal_text_to_fixed_point_top.sv -----
// Top level of the decimal text to fixed point converter.
//
//  port group | dir | carries
//  req_       | in  | one character a word, tlast on the final character
//  rsp_       | out | one result word per string: value, found, overflow
//
// The parser takes one character per cycle while the job queue has room.
// Scaling multiplies by ten once per positive power of ten (stops early on overflow),
// or runs the limb-serial /10 over LIMB_COUNT limbs per negative power (6 at default
// widths), ending early once the numerator reaches zero.
// Synchronous reset clears parser, queue and scaler control; no clearing pass.
// A held result stalls the scaler; once the two-entry queue fills, req_tready drops.
`include "decimal_text_to_fixed_point_top_macros.svh"

module decimal_text_to_fixed_point_top #(
   parameter int VALUE_BITS   = dtfp_pkg::VALUE_BITS_DEF,
   parameter int FRAC_BITS    = dtfp_pkg::FRAC_BITS_DEF,
   parameter int MAX_EXPONENT = dtfp_pkg::MAX_EXPONENT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dtfp_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [7:0] char_code
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [63:0] value, [64] found_number, [65] overflow, [71:66] zero
   output logic [dtfp_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import dtfp_pkg::*;

   localparam int NMAG_W = $clog2(MAX_EXPONENT + int'(FRAC_COUNT_MAX) + 1);
   localparam int JOB_W  = FLAGS_W + NMAG_W + MANT_W;
   localparam int PAD_W  = RSP_TDATA_W - RESULT_W - 2;

   logic                take;
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_not_empty;
   job_flags_type       push_flags;
   logic [MANT_W-1:0]   push_mant;
   logic [NMAG_W-1:0]   push_net_mag;
   logic [JOB_W-1:0]    q_in_data;
   logic [JOB_W-1:0]    q_out_data;
   job_flags_type       job_flags;
   logic [MANT_W-1:0]   job_mant;
   logic [NMAG_W-1:0]   job_net_mag;
   logic [RESULT_W-1:0] value;
   logic                found;
   logic                overflow;

   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   dtfp_front #(
      .MAX_EXPONENT (MAX_EXPONENT),
      .NMAG_W       (NMAG_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .char_code    (req_tdata[CHAR_W-1:0]),
      .last_char    (req_tlast),
      .push         (q_push),
      .push_flags   (push_flags),
      .push_mant    (push_mant),
      .push_net_mag (push_net_mag)
   );

   assign q_in_data = {push_flags, push_net_mag, push_mant};

   dtfp_queue #(
      .DATA_W (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .not_empty (q_not_empty)
   );

   assign {job_flags, job_net_mag, job_mant} = q_out_data;

   dtfp_back #(
      .VALUE_BITS (VALUE_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .NMAG_W     (NMAG_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (q_not_empty),
      .job_flags    (job_flags),
      .job_mant     (job_mant),
      .job_net_mag  (job_net_mag),
      .job_pop      (q_pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_value    (value),
      .rsp_found    (found),
      .rsp_overflow (overflow)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, overflow, found, value};

   `DTFP_ASSERT_IMPL(a_push_has_room, clock, reset, q_push, !q_full)
   `DTFP_ASSERT_IMPL(a_pop_has_job, clock, reset, q_pop, q_not_empty)
   `DTFP_ASSERT_NEXT(a_one_job_at_a_time, clock, reset, q_pop, !q_pop)
   `DTFP_ASSERT_IMPL(a_no_number_is_zero, clock, reset, rsp_tvalid && !found, value == '0 && !overflow)

endmodule

// ----- tb/decimal_text_to_fixed_point_top_test.sv -----
// Testbench for the decimal text to fixed point converter: directed and random strings.
`timescale 1ns / 100ps

module decimal_text_to_fixed_point_top_test;
   import dtfp_pkg::*;

   localparam int          FRAC_BITS    = FRAC_BITS_DEF;
   localparam int          VALUE_BITS   = VALUE_BITS_DEF;
   localparam int          MAX_EXPONENT = MAX_EXPONENT_DEF;
   localparam int          RANDOM_CHARS = 1000;
   localparam int          CALM_TAIL    = 150;
   localparam int          LONG_HOLD    = 400;
   localparam int          DRAIN_CYCLES = 1500;
   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam logic [7:0]  CHAR_SPACE   = 8'h20;

   typedef struct {
      logic [63:0] value;
      bit          found;
      bit          overflow;
   } parsed_number_type;

   class fixed_point_checker;
      phase_type         phase;
      bit                negative;
      logic [63:0]       mantissa;
      int                frac_digits;
      int                exp_value;
      bit                exp_negative;
      bit                saturated;
      parsed_number_type pending_numbers[$];
      int                errors;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         phase        = PH_SKIP;
         negative     = 1'b0;
         mantissa     = '0;
         frac_digits  = 0;
         exp_value    = 0;
         exp_negative = 1'b0;
         saturated    = 1'b0;
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CHAR_ZERO && c <= CHAR_NINE;
      endfunction

      function bit fits(logic [63:0] d);
         return mantissa <= (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10;
      endfunction

      // magnitude of mantissa * 10^net in Q31.32, clamped to lim
      function logic [63:0] scaled_magnitude(input logic [63:0] lim, output bit ovf);
         int           net;
         logic [63:0]  ilim;
         logic [63:0]  p;
         logic [127:0] num;
         net = (exp_negative ? -exp_value : exp_value) - frac_digits;
         ovf = 1'b0;
         if (saturated) begin
            ovf = 1'b1;
            return lim;
         end
         if (mantissa == 0) return '0;
         if (net >= 0) begin
            ilim = lim >> FRAC_BITS;
            p = mantissa;
            if (p > ilim) begin
               ovf = 1'b1;
               return lim;
            end
            for (int i = 0; i < net; i++) begin
               if (p > ilim / 64'd10) begin
                  ovf = 1'b1;
                  return lim;
               end
               p = p * 64'd10;
            end
            return p << FRAC_BITS;
         end
         num = {64'd0, mantissa} << FRAC_BITS;
         for (int k = 0; k < -net; k++) num = num / 128'd10;
         if (num[127:64] != 0 || num[63:0] > lim) begin
            ovf = 1'b1;
            return lim;
         end
         return num[63:0];
      endfunction

      function void take_char(logic [7:0] c, bit last);
         logic [63:0]       d;
         logic [63:0]       half;
         logic [63:0]       lim;
         logic [63:0]       mag;
         bit                ovf;
         int                e;
         parsed_number_type r;
         d = 64'(c) - 64'(CHAR_ZERO);
         case (phase)
            PH_SKIP: begin
               if (is_digit(c)) begin
                  mantissa = d;
                  phase = PH_INT;
               end else if (c == CHAR_MINUS) begin
                  negative = 1'b1;
                  phase = PH_INT;
               end
            end
            PH_INT: begin
               if (is_digit(c)) begin
                  if (fits(d)) mantissa = mantissa * 64'd10 + d;
                  else saturated = 1'b1;
               end else if (c == CHAR_POINT) phase = PH_FRAC;
               else if (c == CHAR_E_LOW || c == CHAR_E_UP) phase = PH_EMARK;
               else phase = PH_DONE;
            end
            PH_FRAC: begin
               if (is_digit(c)) begin
                  if (frac_digits < int'(FRAC_COUNT_MAX) && fits(d)) begin
                     mantissa = mantissa * 64'd10 + d;
                     frac_digits++;
                  end
               end else if (c == CHAR_E_LOW || c == CHAR_E_UP) phase = PH_EMARK;
               else phase = PH_DONE;
            end
            PH_EMARK: begin
               if (c == CHAR_PLUS) phase = PH_EDIG;
               else if (c == CHAR_MINUS) begin
                  exp_negative = 1'b1;
                  phase = PH_EDIG;
               end else phase = PH_DONE;
            end
            PH_EDIG: begin
               if (is_digit(c)) begin
                  e = exp_value * 10 + int'(d);
                  exp_value = (e > MAX_EXPONENT) ? MAX_EXPONENT : e;
               end else phase = PH_DONE;
            end
            default: ;
         endcase
         if (!last) return;
         half = 64'd1 << (VALUE_BITS - 1);
         lim = negative ? half : half - 64'd1;
         r.found = (phase != PH_SKIP);
         ovf = 1'b0;
         mag = r.found ? scaled_magnitude(lim, ovf) : 64'd0;
         r.value = negative ? -mag : mag;
         r.overflow = ovf;
         pending_numbers.push_back(r);
         clear();
      endfunction

      function void check_word(logic [RSP_TDATA_W-1:0] w);
         parsed_number_type x;
         if (pending_numbers.size() == 0) begin
            $error("result word with no string pending: %h", w);
            errors++;
            return;
         end
         x = pending_numbers.pop_front();
         if (w[63:0] !== x.value) begin
            $error("value: expected %h, got %h", x.value, w[63:0]);
            errors++;
         end
         if (w[64] !== x.found) begin
            $error("found_number: expected %0b, got %0b", x.found, w[64]);
            errors++;
         end
         if (w[65] !== x.overflow) begin
            $error("overflow: expected %0b, got %0b", x.overflow, w[65]);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [7:0] char_code
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [63:0] value, [64] found_number, [65] overflow

   fixed_point_checker parse_check = new();

   bit idle_on = 1'b1;
   bit hold_active = 1'b0;
   bit long_hold_request = 1'b0;
   int chars_sent = 0;
   int cycle_count = 0;

   string directed_texts[23] = '{
      "7", "-", "x!", "0.5", "123.456", "-1.5e+3", "2.5E-2", "1e5", "3e-",
      "99999999999999999999999", "0.1234567890123456789012345678901234567",
      "1e+999", "2147483647.9999999999", "2147483648", "-2147483648",
      "-2147483648.1", "-0", "-0.0e-5", "5e-99", "1.5x42", "abc-12",
      "18446744073709551615", "E+5"
   };

   decimal_text_to_fixed_point_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // inputs are noted before results so that order within the edge does not matter
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) parse_check.take_char(req_tdata[7:0], req_tlast);
         if (rsp_tvalid && rsp_tready) parse_check.check_word(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [7:0] random_digit();
      return 8'(CHAR_ZERO + $urandom_range(0, 9));
   endfunction

   // anything the parser skips before a number starts
   function automatic logic [7:0] filler_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_MINUS) c = CHAR_SPACE;
      return c;
   endfunction

   function automatic void make_number_text(ref logic [7:0] txt[$]);
      int kind;
      int n;
      txt.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) txt.push_back(filler_char());
      if ($urandom_range(0, 1)) txt.push_back(CHAR_MINUS);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 22) : $urandom_range(0, 6);
      repeat (n) txt.push_back(random_digit());
      if ($urandom_range(0, 1)) begin
         txt.push_back(CHAR_POINT);
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 36) : $urandom_range(0, 8);
         repeat (n) txt.push_back(random_digit());
      end
      if ($urandom_range(0, 2) == 0) begin
         txt.push_back($urandom_range(0, 1) ? CHAR_E_LOW : CHAR_E_UP);
         case ($urandom_range(0, 5))
            0: ;
            1, 2: txt.push_back(CHAR_PLUS);
            default: txt.push_back(CHAR_MINUS);
         endcase
         repeat ($urandom_range(0, 3)) txt.push_back(random_digit());
      end
      if ($urandom_range(0, 4) == 0) txt.push_back(8'($urandom_range(0, 255)));
      if (txt.size() == 0) txt.push_back(random_digit());
      // broken sequence: a stray byte somewhere inside
      if (kind == 1) txt.insert($urandom_range(0, txt.size() - 1), 8'($urandom_range(0, 255)));
   endfunction

   task automatic send_text(input logic [7:0] txt[$]);
      for (int i = 0; i < txt.size(); i++) begin
         req_tvalid <= 1'b1;
         req_tdata  <= txt[i];
         req_tlast  <= (i == txt.size() - 1);
         do @(posedge clock); while (!req_tready);
         chars_sent++;
         if (idle_on && !hold_active && $urandom_range(0, 5) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   endtask

   // result side: random stalls, plus one long hold so the input backs up
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            rsp_tready <= 1'b0;
            hold_active = 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_active = 1'b0;
            long_hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      logic [7:0] txt[$];
      int         next_toggle;
      int         random_end;
      bit         hold_asked;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      hold_asked = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_texts[k]) begin
         txt.delete();
         for (int i = 0; i < directed_texts[k].len(); i++) txt.push_back(directed_texts[k][i]);
         send_text(txt);
      end

      random_end = chars_sent + RANDOM_CHARS;
      next_toggle = chars_sent + 150;
      while (chars_sent < random_end) begin
         if (chars_sent >= next_toggle) begin
            idle_on = ($urandom_range(0, 3) != 0);
            next_toggle += 150;
         end
         if (chars_sent >= random_end - CALM_TAIL) idle_on = 1'b0;
         if (!hold_asked && chars_sent >= 400) begin
            long_hold_request = 1'b1;
            hold_asked = 1'b1;
         end
         make_number_text(txt);
         send_text(txt);
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      while (parse_check.pending_numbers.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (parse_check.errors == 0 && parse_check.pending_numbers.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/dtfp_pkg.sv
sv/dtfp_front.sv
sv/dtfp_queue.sv
sv/dtfp_back.sv
sv/decimal_text_to_fixed_point_top.sv
tb/decimal_text_to_fixed_point_top_test.sv
